// ----- rtl/cantx_pkg.sv -----
// Shared types and constants for the CAN transmit-buffer loader.
package cantx_pkg;

  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam int unsigned CFG_IDX_W      = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CMD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODIFY_CMD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_CMD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF0_ADDR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF1_ADDR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF2_ADDR   = 3'd5;

  // register reset values
  localparam logic [7:0] RST_WRITE_CMD  = 8'h02;
  localparam logic [7:0] RST_MODIFY_CMD = 8'h05;
  localparam logic [7:0] RST_LOAD_CMD   = 8'h40;
  localparam logic [7:0] RST_BUF0_ADDR  = 8'h30;
  localparam logic [7:0] RST_BUF1_ADDR  = 8'h40;
  localparam logic [7:0] RST_BUF2_ADDR  = 8'h50;

  localparam logic [7:0] STATUS_MASK = 8'h54;
  localparam logic [7:0] RTR_FLAG    = 8'h40;
  localparam logic [7:0] MODIFY_MASK = 8'h03;
  localparam logic [7:0] MODIFY_DATA = 8'h03;
  localparam logic [7:0] TX_REQUEST  = 8'h08;
  localparam logic [1:0] PRIO_TOP    = 2'd3;
  localparam logic [1:0] PRIO_WRAP   = 2'd2;

  typedef enum logic [1:0] {
    BUF0 = 2'd0,
    BUF1 = 2'd1,
    BUF2 = 2'd2
  } buf_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_START  = 7'b0000010,
    ST_RAISE  = 7'b0000100,
    ST_LOAD   = 7'b0001000,
    ST_DATA   = 7'b0010000,
    ST_CTRL   = 7'b0100000,
    ST_REJECT = 7'b1000000
  } state_t;

  typedef struct packed {
    state_t phase;
    logic   load;
    logic   emit;
  } cantx_cmd_t;

  typedef struct packed {
    logic reject;
    logic raise;
    logic no_data;
    logic phase_last;
    logic out_free;
  } cantx_stat_t;

endpackage

// ----- rtl/cantx_ctrl.sv -----
// Sequencer that steps one frame through its SPI transactions.
module cantx_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  cantx_pkg::cantx_stat_t stat,
  output cantx_pkg::cantx_cmd_t  cmd
);
  import cantx_pkg::*;

  state_t state, state_next;
  logic   emitting;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign emitting = (state == ST_RAISE) || (state == ST_LOAD) || (state == ST_DATA) ||
                    (state == ST_CTRL) || (state == ST_REJECT);

  assign in_stall  = (state != ST_IDLE);
  assign cmd.phase = state;
  assign cmd.load  = (state == ST_IDLE) && in_valid;
  assign cmd.emit  = emitting && stat.out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_START;
      end
      ST_START: begin
        if (stat.reject)     state_next = ST_REJECT;
        else if (stat.raise) state_next = ST_RAISE;
        else                 state_next = ST_LOAD;
      end
      ST_RAISE: begin
        if (cmd.emit && stat.phase_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (cmd.emit && stat.phase_last) state_next = stat.no_data ? ST_CTRL : ST_DATA;
      end
      ST_DATA: begin
        if (cmd.emit && stat.phase_last) state_next = ST_CTRL;
      end
      ST_CTRL: begin
        if (cmd.emit && stat.phase_last) state_next = ST_IDLE;
      end
      ST_REJECT: begin
        if (cmd.emit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/cantx_dpath.sv -----
// Frame capture, buffer choice, priority counter, byte mux and output register.
module cantx_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [cantx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_data,
  input  logic [7:0]                        device_status,
  input  logic [28:0]                       frame_id,
  input  logic                              extended_frame,
  input  logic                              remote_request,
  input  logic [3:0]                        length_code,
  input  logic [63:0]                       payload,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        spi_byte,
  output logic                              byte_valid,
  output logic                              end_of_select,
  output logic                              accepted,
  output logic                              last,
  input  cantx_pkg::cantx_cmd_t             cmd,
  output cantx_pkg::cantx_stat_t            stat
);
  import cantx_pkg::*;

  logic [7:0]  write_cmd, modify_cmd, load_cmd, buf0_addr, buf1_addr, buf2_addr;
  logic [1:0]  prio, prio_next;
  buf_t        sel, sel_next;
  logic        reject, reject_next, raise, raise_next;
  logic        ext, rtr, no_data;
  logic [3:0]  dlc, len;
  logic [28:0] id;
  logic [63:0] data;
  logic [2:0]  cnt;
  logic [7:0]  status_bits, ctrl_addr, id_b1, id_b2, id_b3, id_b4;
  logic [3:0]  len_in;
  logic [7:0]  byte_d;
  logic        eos_d, bv_d, acc_d, last_d, phase_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_cmd  <= RST_WRITE_CMD;
      modify_cmd <= RST_MODIFY_CMD;
      load_cmd   <= RST_LOAD_CMD;
      buf0_addr  <= RST_BUF0_ADDR;
      buf1_addr  <= RST_BUF1_ADDR;
      buf2_addr  <= RST_BUF2_ADDR;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WRITE_CMD:  write_cmd  <= cfg_data;
        CFG_MODIFY_CMD: modify_cmd <= cfg_data;
        CFG_LOAD_CMD:   load_cmd   <= cfg_data;
        CFG_BUF0_ADDR:  buf0_addr  <= cfg_data;
        CFG_BUF1_ADDR:  buf1_addr  <= cfg_data;
        CFG_BUF2_ADDR:  buf2_addr  <= cfg_data;
        default: ;
      endcase
    end
  end

  // buffer choice from pending flags of buffers 2,1,0
  assign status_bits = device_status & STATUS_MASK;
  always_comb begin
    sel_next    = BUF2;
    reject_next = 1'b0;
    raise_next  = 1'b0;
    prio_next   = prio;
    case ({status_bits[6], status_bits[4], status_bits[2]})
      3'b000: begin
        sel_next  = BUF2;
        prio_next = PRIO_TOP;
      end
      3'b100, 3'b101: sel_next = BUF1;
      3'b010, 3'b110: sel_next = BUF0;
      3'b001, 3'b011: begin
        sel_next = BUF2;
        if (prio == 2'd0) begin
          raise_next = 1'b1;
          prio_next  = PRIO_WRAP;
        end else begin
          prio_next = prio - 2'd1;
        end
      end
      default: reject_next = 1'b1;
    endcase
  end

  assign len_in = (length_code > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES) : length_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      prio   <= PRIO_TOP;
      reject <= 1'b0;
      raise  <= 1'b0;
    end else if (cmd.load) begin
      reject <= reject_next;
      raise  <= raise_next;
      if (!reject_next) prio <= prio_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sel     <= sel_next;
      ext     <= extended_frame;
      rtr     <= remote_request;
      dlc     <= length_code;
      len     <= len_in;
      no_data <= remote_request || (len_in == 4'd0);
      id      <= frame_id;
      data    <= payload;
    end
  end

  // byte position within the current transaction group
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      cnt <= '0;
    end else if (cmd.emit) begin
      cnt <= phase_last ? 3'd0 : cnt + 3'd1;
    end
  end

  always_comb begin
    case (cmd.phase)
      ST_RAISE:  phase_last = (cnt == 3'd7);
      ST_LOAD:   phase_last = (cnt == 3'd5);
      ST_DATA:   phase_last = ({1'b0, cnt} == len - 4'd1);
      ST_CTRL:   phase_last = (cnt == 3'd2);
      ST_REJECT: phase_last = 1'b1;
      default:   phase_last = 1'b0;
    endcase
  end

  always_comb begin
    case (sel)
      BUF0:    ctrl_addr = buf0_addr;
      BUF1:    ctrl_addr = buf1_addr;
      default: ctrl_addr = buf2_addr;
    endcase
  end

  // identifier packing: extended splits SID/EID, standard puts 11 bits in the top two
  always_comb begin
    if (ext) begin
      id_b1 = id[28:21];
      id_b2 = {id[20:18], 1'b0, 1'b1, 1'b0, id[17:16]};
      id_b3 = id[15:8];
      id_b4 = id[7:0];
    end else begin
      id_b1 = id[10:3];
      id_b2 = {id[2:0], 5'b0};
      id_b3 = 8'h00;
      id_b4 = 8'h00;
    end
  end

  always_comb begin
    byte_d = 8'h00;
    eos_d  = 1'b0;
    bv_d   = 1'b1;
    acc_d  = 1'b1;
    last_d = 1'b0;
    case (cmd.phase)
      ST_RAISE: begin
        case (cnt[1:0])
          2'd0:    byte_d = modify_cmd;
          2'd1:    byte_d = cnt[2] ? buf0_addr : buf1_addr;
          2'd2:    byte_d = MODIFY_MASK;
          default: byte_d = MODIFY_DATA;
        endcase
        eos_d = (cnt[1:0] == 2'd3);
      end
      ST_LOAD: begin
        case (cnt)
          3'd0:    byte_d = load_cmd | {5'b0, sel, 1'b0};
          3'd1:    byte_d = id_b1;
          3'd2:    byte_d = id_b2;
          3'd3:    byte_d = id_b3;
          3'd4:    byte_d = id_b4;
          default: byte_d = rtr ? ({4'b0, dlc} | RTR_FLAG) : {4'b0, dlc};
        endcase
        eos_d = phase_last && no_data;
      end
      ST_DATA: begin
        byte_d = data[{cnt, 3'b000} +: 8];
        eos_d  = phase_last;
      end
      ST_CTRL: begin
        case (cnt)
          3'd0:    byte_d = write_cmd;
          3'd1:    byte_d = ctrl_addr;
          default: byte_d = {6'b0, prio} | TX_REQUEST;
        endcase
        eos_d  = phase_last;
        last_d = phase_last;
      end
      ST_REJECT: begin
        bv_d   = 1'b0;
        acc_d  = 1'b0;
        last_d = 1'b1;
      end
      default: begin
        bv_d  = 1'b0;
        acc_d = 1'b0;
      end
    endcase
  end

  // output register parts the sequencer from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      spi_byte      <= byte_d;
      byte_valid    <= bv_d;
      end_of_select <= eos_d;
      accepted      <= acc_d;
      last          <= last_d;
    end
  end

  assign stat.reject     = reject;
  assign stat.raise      = raise;
  assign stat.no_data    = no_data;
  assign stat.phase_last = phase_last;
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

// ----- rtl/can_tx_buffer_pick_and_load.sv -----
// Top level of the CAN transmit-buffer picker and SPI byte-stream loader.
// Each accepted request (a CAN frame plus the controller status byte) picks a
// free transmit buffer and produces the SPI bytes that load and launch it, one
// result per byte: 9 to 25 bytes for an accepted frame, or one rejection
// result when all three buffers are pending. Each request is accepted, then its
// buffer is decided, and then the sequencer places one result per cycle into the
// output register whenever the output is not stalled. The next request is taken
// as soon as the final byte sits in the output register. Configuration registers
// are always ready and must only be written while the block is idle.
module can_tx_buffer_pick_and_load (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cantx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       device_status,
  input  logic [28:0]                      frame_id,
  input  logic                             extended_frame,
  input  logic                             remote_request,
  input  logic [3:0]                       length_code,
  input  logic [63:0]                      payload,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       spi_byte,
  output logic                             byte_valid,
  output logic                             end_of_select,
  output logic                             accepted,
  output logic                             last
);
  import cantx_pkg::*;

  cantx_cmd_t  cmd;
  cantx_stat_t stat;

  assign cfg_ready = 1'b1;

  cantx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cantx_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .device_status  (device_status),
    .frame_id       (frame_id),
    .extended_frame (extended_frame),
    .remote_request (remote_request),
    .length_code    (length_code),
    .payload        (payload),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .spi_byte       (spi_byte),
    .byte_valid     (byte_valid),
    .end_of_select  (end_of_select),
    .accepted       (accepted),
    .last           (last),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// ----- rtl/cantx_check.sv -----
// Port-level checks for the CAN transmit-buffer loader, bound to the top level.
module cantx_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] spi_byte,
  input logic       byte_valid,
  input logic       end_of_select,
  input logic       accepted,
  input logic       last
);

  // held result does not change under stall
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(spi_byte) && $stable(last))
    else $error("result changed while stalled");

  // a rejection is a single empty result
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> last && !byte_valid && !end_of_select)
    else $error("malformed rejection result");

  // the final byte of an accepted frame closes an SPI transaction
  a_last_eos: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted && last |-> end_of_select && byte_valid)
    else $error("frame ended inside a transaction");

  // one request at a time: the block is busy right after taking a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken back to back");

endmodule

bind can_tx_buffer_pick_and_load cantx_check u_check (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the CAN transmit-buffer picker and SPI loader.
module tb;
  import cantx_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int DIR_ROWS        = 20;
  localparam int ITEMS_PER_PHASE = 147;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int MAX_REPORTS     = 60;

  // pending-flag patterns after masking the status byte
  localparam logic [7:0] PEND_NONE = 8'h00;
  localparam logic [7:0] PEND_B0   = 8'h04;
  localparam logic [7:0] PEND_B1   = 8'h10;
  localparam logic [7:0] PEND_B2   = 8'h40;
  // load-opcode offsets per buffer
  localparam logic [7:0] OFS_BUF0  = 8'h00;
  localparam logic [7:0] OFS_BUF1  = 8'h02;
  localparam logic [7:0] OFS_BUF2  = 8'h04;
  localparam logic [7:0] EXIDE_FLAG = 8'h08;

  typedef struct packed {
    logic [7:0]  status;
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    logic [3:0]  dlc;
    logic [63:0] data;
  } frame_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       end_of_select;
    logic       accepted;
    logic       last;
  } spi_res_t;

  typedef struct packed {
    frame_t   frm;
    logic     typed;
    spi_res_t exp;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           device_status;
  logic [28:0]          frame_id;
  logic                 extended_frame;
  logic                 remote_request;
  logic [3:0]           length_code;
  logic [63:0]          payload;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           spi_byte;
  logic                 byte_valid;
  logic                 end_of_select;
  logic                 accepted;
  logic                 last;

  spi_res_t   spi_due[$];
  spi_res_t   due_res;
  logic [7:0] reg_shadow [0:5];
  logic [1:0] prio_shadow;
  dir_row_t   dir_rows [0:DIR_ROWS-1];

  int mismatch_count  = 0;
  int results_checked = 0;
  int rejects_seen    = 0;
  int frames_sent     = 0;
  int wraps_due       = 0;
  int in_idle_pct     = 0;
  int out_idle_pct    = 0;
  int held            = 0;
  logic hold_arm      = 1'b0;

  can_tx_buffer_pick_and_load u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .device_status  (device_status),
    .frame_id       (frame_id),
    .extended_frame (extended_frame),
    .remote_request (remote_request),
    .length_code    (length_code),
    .payload        (payload),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .spi_byte       (spi_byte),
    .byte_valid     (byte_valid),
    .end_of_select  (end_of_select),
    .accepted       (accepted),
    .last           (last)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void push_byte(logic [7:0] b, logic eos, logic lst);
    spi_due.push_back('{b, 1'b1, eos, 1'b1, lst});
  endfunction

  // Expected SPI bytes for one accepted request, or its rejection result; updates the priority shadow.
  function automatic void predict_load_stream(frame_t f);
    logic [7:0] pend;
    logic [7:0] ctrl;
    logic [7:0] ofs;
    logic [7:0] addr;
    logic       raise;
    int         n_data;
    pend  = f.status & STATUS_MASK;
    raise = 1'b0;
    case (pend)
      PEND_NONE: begin
        ctrl        = reg_shadow[CFG_BUF2_ADDR];
        ofs         = OFS_BUF2;
        prio_shadow = PRIO_TOP;
      end
      PEND_B2, PEND_B2 | PEND_B0: begin
        ctrl = reg_shadow[CFG_BUF1_ADDR];
        ofs  = OFS_BUF1;
      end
      PEND_B1, PEND_B2 | PEND_B1: begin
        ctrl = reg_shadow[CFG_BUF0_ADDR];
        ofs  = OFS_BUF0;
      end
      PEND_B0, PEND_B1 | PEND_B0: begin
        ctrl = reg_shadow[CFG_BUF2_ADDR];
        ofs  = OFS_BUF2;
        if (prio_shadow == 2'd0) begin
          raise       = 1'b1;
          prio_shadow = PRIO_WRAP;
          wraps_due++;
        end else begin
          prio_shadow = prio_shadow - 2'd1;
        end
      end
      default: begin
        // all three buffers busy
        spi_due.push_back('{8'h00, 1'b0, 1'b0, 1'b0, 1'b1});
        return;
      end
    endcase

    if (raise) begin
      // counter wrapped: lift buffer 1, then buffer 0, to top priority
      for (int k = 0; k < 2; k++) begin
        addr = (k == 0) ? reg_shadow[CFG_BUF1_ADDR] : reg_shadow[CFG_BUF0_ADDR];
        push_byte(reg_shadow[CFG_MODIFY_CMD], 1'b0, 1'b0);
        push_byte(addr, 1'b0, 1'b0);
        push_byte(MODIFY_MASK, 1'b0, 1'b0);
        push_byte(MODIFY_DATA, 1'b1, 1'b0);
      end
    end

    push_byte(reg_shadow[CFG_LOAD_CMD] | ofs, 1'b0, 1'b0);
    if (f.ext) begin
      push_byte(f.id[28:21], 1'b0, 1'b0);
      push_byte({f.id[20:18], 5'h00} | {6'h00, f.id[17:16]} | EXIDE_FLAG, 1'b0, 1'b0);
      push_byte(f.id[15:8], 1'b0, 1'b0);
      push_byte(f.id[7:0], 1'b0, 1'b0);
    end else begin
      // standard id: bits above 10 fall off
      push_byte(f.id[10:3], 1'b0, 1'b0);
      push_byte({f.id[2:0], 5'h00}, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
    end

    n_data = (f.dlc > MAX_DATA_BYTES) ? MAX_DATA_BYTES : int'(f.dlc);
    if (f.rtr || n_data == 0) begin
      push_byte(f.rtr ? ({4'h0, f.dlc} | RTR_FLAG) : {4'h0, f.dlc}, 1'b1, 1'b0);
    end else begin
      push_byte({4'h0, f.dlc}, 1'b0, 1'b0);
      for (int i = 0; i < n_data; i++)
        push_byte(f.data[8*i +: 8], i == n_data - 1, 1'b0);
    end

    push_byte(reg_shadow[CFG_WRITE_CMD], 1'b0, 1'b0);
    push_byte(ctrl, 1'b0, 1'b0);
    push_byte({6'h00, prio_shadow} | TX_REQUEST, 1'b1, 1'b1);
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    int     cls;
    cls      = $urandom_range(99);
    f.status = 8'($urandom_range(255)) & ~STATUS_MASK;
    // weighted toward buffer-2 use so the priority counter wraps often
    if (cls < 8)       f.status |= PEND_NONE;
    else if (cls < 28) f.status |= PEND_B0;
    else if (cls < 48) f.status |= PEND_B1 | PEND_B0;
    else if (cls < 58) f.status |= PEND_B2;
    else if (cls < 68) f.status |= PEND_B2 | PEND_B0;
    else if (cls < 78) f.status |= PEND_B1;
    else if (cls < 88) f.status |= PEND_B2 | PEND_B1;
    else               f.status |= PEND_B2 | PEND_B1 | PEND_B0;
    case ($urandom_range(9))
      0:       f.id = '0;
      1:       f.id = '1;
      2:       f.id = 29'($urandom_range(2047));
      default: f.id = 29'($urandom);
    endcase
    f.ext  = 1'($urandom_range(1));
    f.rtr  = ($urandom_range(3) == 0);
    f.dlc  = ($urandom_range(5) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    f.data = {$urandom, $urandom};
    return f;
  endfunction

  task automatic send_frame(frame_t f, logic typed, spi_res_t typed_res);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    device_status  <= f.status;
    frame_id       <= f.id;
    extended_frame <= f.ext;
    remote_request <= f.rtr;
    length_code    <= f.dlc;
    payload        <= f.data;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) spi_due.push_back(typed_res);
    else predict_load_stream(f);
    frames_sent++;
  endtask

  // Writes every index, spare ones included; spare writes must be ignored.
  task automatic load_regs(logic [7:0] base_val, logic rand_vals);
    logic [7:0] val;
    for (int i = 0; i < 8; i++) begin
      val = (rand_vals || i > CFG_BUF2_ADDR) ? 8'($urandom_range(255)) : base_val;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= val;
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (i <= CFG_BUF2_ADDR) reg_shadow[i] = val;
    end
    cfg_valid <= 1'b0;
  endtask

  // receiver side: random stalls plus one long hold-off when armed
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_arm && held < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        held++;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (spi_due.size() == 0) begin
        report_mismatch("result with nothing due", 64'(spi_byte), 64'h0);
      end else begin
        due_res = spi_due.pop_front();
        if (spi_byte !== due_res.data)
          report_mismatch("spi_byte", 64'(spi_byte), 64'(due_res.data));
        if (byte_valid !== due_res.byte_valid)
          report_mismatch("byte_valid", 64'(byte_valid), 64'(due_res.byte_valid));
        if (end_of_select !== due_res.end_of_select)
          report_mismatch("end_of_select", 64'(end_of_select),
                          64'(due_res.end_of_select));
        if (accepted !== due_res.accepted)
          report_mismatch("accepted", 64'(accepted), 64'(due_res.accepted));
        if (last !== due_res.last)
          report_mismatch("last", 64'(last), 64'(due_res.last));
        if (due_res.last && !due_res.accepted) rejects_seen++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still due", spi_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    device_status  <= '0;
    frame_id       <= '0;
    extended_frame <= 1'b0;
    remote_request <= 1'b0;
    length_code    <= '0;
    payload        <= '0;

    reg_shadow[CFG_WRITE_CMD]  = RST_WRITE_CMD;
    reg_shadow[CFG_MODIFY_CMD] = RST_MODIFY_CMD;
    reg_shadow[CFG_LOAD_CMD]   = RST_LOAD_CMD;
    reg_shadow[CFG_BUF0_ADDR]  = RST_BUF0_ADDR;
    reg_shadow[CFG_BUF1_ADDR]  = RST_BUF1_ADDR;
    reg_shadow[CFG_BUF2_ADDR]  = RST_BUF2_ADDR;
    prio_shadow = PRIO_TOP;

    // status, id, ext, rtr, dlc, data | typed | expected (rejections only)
    dir_rows = '{
      '{'{8'h00, 29'h0000000, 1'b0, 1'b0, 4'd0,  64'h0}, 1'b0, '0},
      '{'{8'hFF, 29'h1FFFFFFF, 1'b1, 1'b1, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{8'h04, 29'h1FFFFFFF, 1'b0, 1'b0, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0},
      '{'{8'h14, 29'h1FFFFFFF, 1'b1, 1'b1, 4'd15, 64'h0}, 1'b0, '0},
      '{'{8'h04, 29'h0000000, 1'b1, 1'b0, 4'd9,  64'h0123_4567_89AB_CDEF}, 1'b0, '0},
      '{'{8'h14, 29'h00007FF, 1'b0, 1'b0, 4'd1,  64'h0000_0000_0000_00A5}, 1'b0, '0},
      '{'{8'h40, 29'h12345678, 1'b1, 1'b0, 4'd4, 64'h1122_3344_5566_7788}, 1'b0, '0},
      '{'{8'h44, 29'h0000555, 1'b0, 1'b1, 4'd0,  64'h0}, 1'b0, '0},
      '{'{8'h10, 29'h0AAAAAAA, 1'b1, 1'b0, 4'd8, 64'h8000_0000_0000_0001}, 1'b0, '0},
      '{'{8'h50, 29'h0000400, 1'b0, 1'b0, 4'd2,  64'hDEAD_BEEF_CAFE_F00D}, 1'b0, '0},
      '{'{8'h54, 29'h0000000, 1'b0, 1'b0, 4'd0,  64'h0}, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{8'hAB, 29'h15555555, 1'b1, 1'b0, 4'd7, 64'h0F1E_2D3C_4B5A_6978}, 1'b0, '0},
      '{'{8'h04, 29'h0000123, 1'b0, 1'b0, 4'd3,  64'h0000_0000_00C0_FFEE}, 1'b0, '0},
      '{'{8'h2E, 29'h1000000, 1'b1, 1'b1, 4'd8,  64'h5555_AAAA_5555_AAAA}, 1'b0, '0},
      '{'{8'h14, 29'h0000001, 1'b0, 1'b0, 4'd5,  64'hAAAA_5555_AAAA_5555}, 1'b0, '0},
      '{'{8'hBD, 29'h0FFFFFF, 1'b1, 1'b0, 4'd6,  64'h7766_5544_3322_1100}, 1'b0, '0},
      '{'{8'h00, 29'h00007FF, 1'b0, 1'b1, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0},
      '{'{8'hD5, 29'h1FFFFFFF, 1'b1, 1'b0, 4'd8, 64'h0}, 1'b1,
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{8'h2A, 29'h0000000, 1'b1, 1'b0, 4'd12, 64'h0102_0304_0506_0708}, 1'b0, '0},
      '{'{8'h40, 29'h1FFFFFFF, 1'b1, 1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    in_idle_pct  = 13;
    out_idle_pct = 78;
    for (int r = 0; r < DIR_ROWS; r++)
      send_frame(dir_rows[r].frm, dir_rows[r].typed, dir_rows[r].exp);
    in_valid <= 1'b0;

    for (int p = 0; p < 3; p++) begin
      while (spi_due.size() != 0) @(posedge clk);
      case (p)
        0: begin
          load_regs(8'hFF, 1'b0);
          in_idle_pct  = 13;
          out_idle_pct = 78;
          hold_arm     = 1'b1;  // long receiver hold while requests keep coming
        end
        1: begin
          load_regs(8'h00, 1'b0);
          in_idle_pct  = 78;
          out_idle_pct = 13;
        end
        default: begin
          load_regs(8'h00, 1'b1);
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_frame(rand_frame(), 1'b0, '0);
      in_valid <= 1'b0;
    end

    while (spi_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d frames over three handshake mixes and four register sets, %0d rejected",
             frames_sent, rejects_seen);
    $display("%0d SPI bytes compared, %0d priority wraps with buffer raise",
             results_checked, wraps_due);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
